// ===== hw/rtl/kmf_pkg.sv =====
package kmf_pkg;

  localparam int MAX_MOTIF_DEF   = 10;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CFG_W   = 4;
  localparam int LEN_W   = 6;
  localparam int POS_W   = 9;
  localparam int CNT_W   = 9;
  localparam int CODE_W  = 20;
  localparam int QUAL_W  = 13;

  localparam logic [POS_W-1:0] POS_SAT = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_CMP,
    ST_FIN
  } kmf_state_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic rd;
    logic next;
    logic bump;
    logic emit;
  } kmf_cmd_t;

  typedef struct packed {
    logic qual;
    logic empty;
    logic hit;
    logic last_entry;
    logic last_item;
    logic out_free;
  } kmf_status_t;

endpackage

// ===== hw/rtl/kmf_in_if.sv =====
interface kmf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] base_code;
  logic       seed_first;
  logic       seed_last;

  modport source (output valid, output base_code, output seed_first, output seed_last,
                  input ready);
  modport sink (input valid, input base_code, input seed_first, input seed_last,
                output ready);
endinterface

// ===== hw/rtl/kmf_out_if.sv =====
interface kmf_out_if;
  logic                         valid;
  logic                         ready;
  logic [kmf_pkg::CODE_W-1:0]   motif_code;
  logic [kmf_pkg::CNT_W-1:0]    top_count;
  logic                         table_full;

  modport source (output valid, output motif_code, output top_count, output table_full,
                  input ready);
  modport sink (input valid, input motif_code, input top_count, input table_full,
                output ready);
endinterface

// ===== hw/rtl/most_frequent_kmer_finder_unit.sv =====
// per nucleotide: accept, evaluate, then a read and a compare state per table entry compared,
// then finish; entries scanned range from 0 to TABLE_DEPTH; a last nucleotide also holds
// the finish state while the output register is still full; the result shows in the
// cycle after the emit in the finish state
// a new nucleotide is taken while an earlier result still waits in the output register
// reset: motif_len returns to 1, window, position, counts and flags clear; no table sweep
module most_frequent_kmer_finder_unit #(
  parameter int MAX_MOTIF   = kmf_pkg::MAX_MOTIF_DEF,
  parameter int TABLE_DEPTH = kmf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [kmf_pkg::CFG_W-1:0] cfg_wdata,
  kmf_in_if.sink                    in_ch,
  kmf_out_if.source                 out_ch
);

  kmf_pkg::kmf_cmd_t    cmd;
  kmf_pkg::kmf_status_t status;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  kmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kmf_dp #(
    .MAX_MOTIF   (MAX_MOTIF),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .base_code  (in_ch.base_code),
    .seed_first (in_ch.seed_first),
    .seed_last  (in_ch.seed_last),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .motif_code (out_ch.motif_code),
    .top_count  (out_ch.top_count),
    .table_full (out_ch.table_full)
  );

  // busy once a transaction is taken
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("input ready right after a transaction");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.insert, cmd.rd, cmd.next, cmd.bump, cmd.emit}))
    else $error("more than one datapath command");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_ch.valid)
    else $error("result not presented after emit");

  a_read_then_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> !cmd.rd && !cmd.load)
    else $error("table read not followed by compare");

endmodule

// ===== hw/rtl/kmf_ctrl.sv =====
module kmf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kmf_pkg::kmf_status_t status,
  output kmf_pkg::kmf_cmd_t    cmd
);

  kmf_pkg::kmf_state_t state;
  kmf_pkg::kmf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kmf_pkg::ST_IDLE: begin
        if (in_valid) state_next = kmf_pkg::ST_EVAL;
      end
      kmf_pkg::ST_EVAL: begin
        if (!status.qual || status.empty) state_next = kmf_pkg::ST_FIN;
        else state_next = kmf_pkg::ST_READ;
      end
      kmf_pkg::ST_READ: begin
        state_next = kmf_pkg::ST_CMP;
      end
      kmf_pkg::ST_CMP: begin
        if (status.hit || status.last_entry) state_next = kmf_pkg::ST_FIN;
        else state_next = kmf_pkg::ST_READ;
      end
      kmf_pkg::ST_FIN: begin
        if (!status.last_item || status.out_free) state_next = kmf_pkg::ST_IDLE;
      end
      default: state_next = kmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      kmf_pkg::ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      kmf_pkg::ST_EVAL: begin
        cmd.insert = status.qual && status.empty;
      end
      kmf_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      kmf_pkg::ST_CMP: begin
        cmd.bump   = status.hit;
        cmd.insert = !status.hit && status.last_entry;
        cmd.next   = !status.hit && !status.last_entry;
      end
      kmf_pkg::ST_FIN: begin
        cmd.emit = status.last_item && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/kmf_dp.sv =====
module kmf_dp #(
  parameter int MAX_MOTIF   = kmf_pkg::MAX_MOTIF_DEF,
  parameter int TABLE_DEPTH = kmf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kmf_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [1:0]                   base_code,
  input  logic                         seed_first,
  input  logic                         seed_last,
  input  kmf_pkg::kmf_cmd_t            cmd,
  output kmf_pkg::kmf_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kmf_pkg::CODE_W-1:0]   motif_code,
  output logic [kmf_pkg::CNT_W-1:0]    top_count,
  output logic                         table_full
);

  localparam int KEY_W  = 2 * MAX_MOTIF;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W  = kmf_pkg::CNT_W;
  localparam int POS_W  = kmf_pkg::POS_W;
  localparam int LEN_W  = kmf_pkg::LEN_W;
  localparam int QUAL_W = kmf_pkg::QUAL_W;
  localparam int CODE_W = kmf_pkg::CODE_W;

  logic [kmf_pkg::CFG_W-1:0] motif_len;
  logic [KEY_W-1:0]          window;
  logic [POS_W-1:0]          pos;
  logic [ENT_W-1:0]          entries;
  logic [CNT_W-1:0]          best_count;
  logic [KEY_W-1:0]          best_key;
  logic                      overflow;
  logic [ADDR_W-1:0]         scan_idx;
  logic                      qual;
  logic                      last_item;
  logic [KEY_W-1:0]          key_q;
  logic [CNT_W-1:0]          cnt_q;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];

  logic [LEN_W-1:0]  eff_len;
  logic [KEY_W-1:0]  mask;
  logic [KEY_W-1:0]  base_window;
  logic [KEY_W-1:0]  window_next;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  pos_next;
  logic              qual_next;
  logic [CNT_W-1:0]  bumped;
  logic              full;
  logic [ADDR_W-1:0] wr_addr;
  logic              key_we;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [KEY_W+CODE_W-1:0] key_wide;

  always_comb begin
    if (motif_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(motif_len) > LEN_W'(MAX_MOTIF)) begin
      eff_len = LEN_W'(MAX_MOTIF);
    end else begin
      eff_len = LEN_W'(motif_len);
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_W; i++) begin
      mask[i] = (i < 2 * int'(eff_len));
    end
  end

  assign base_window = seed_first ? '0 : window;
  assign window_next = {base_window[KEY_W-3:0], base_code} & mask;
  assign cur_pos     = seed_first ? '0 : pos;
  assign pos_next    = (cur_pos == kmf_pkg::POS_SAT) ? cur_pos : cur_pos + POS_W'(1);
  assign qual_next   = (QUAL_W'(cur_pos) * QUAL_W'(10) + QUAL_W'(10))
                       >= (QUAL_W'(eff_len) * QUAL_W'(9));

  assign bumped    = (cnt_q == kmf_pkg::CNT_SAT) ? cnt_q : cnt_q + CNT_W'(1);
  assign full      = (entries == ENT_W'(TABLE_DEPTH));
  assign wr_addr   = cmd.insert ? entries[ADDR_W-1:0] : scan_idx;
  assign key_we    = cmd.insert && !full;
  assign cnt_we    = key_we || cmd.bump;
  assign cnt_wdata = cmd.bump ? bumped : CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) motif_len <= kmf_pkg::CFG_W'(1);
    else if (cfg_we) motif_len <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= window;
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wdata;
    if (cmd.rd) begin
      key_q <= key_mem[scan_idx];
      cnt_q <= cnt_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      pos        <= '0;
      entries    <= '0;
      best_count <= '0;
      best_key   <= '0;
      overflow   <= 1'b0;
      scan_idx   <= '0;
      qual       <= 1'b0;
      last_item  <= 1'b0;
    end else begin
      if (cmd.load) begin
        window    <= window_next;
        pos       <= pos_next;
        qual      <= qual_next;
        last_item <= seed_last;
        scan_idx  <= '0;
        if (seed_first) begin
          entries    <= '0;
          best_count <= '0;
          best_key   <= '0;
          overflow   <= 1'b0;
        end
      end
      if (cmd.next) scan_idx <= scan_idx + ADDR_W'(1);
      if (cmd.insert) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          entries <= entries + ENT_W'(1);
          if (best_count == '0) begin
            best_count <= CNT_W'(1);
            best_key   <= window;
          end
        end
      end
      if (cmd.bump && bumped > best_count) begin
        best_count <= bumped;
        best_key   <= window;
      end
    end
  end

  // result register
  assign key_wide = {{CODE_W{1'b0}}, best_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      motif_code <= key_wide[CODE_W-1:0];
      top_count  <= best_count;
      table_full <= overflow;
    end
  end

  always_comb begin
    status            = '0;
    status.qual       = qual;
    status.empty      = (entries == '0);
    status.hit        = (key_q == window);
    status.last_entry = ((ENT_W'(scan_idx) + ENT_W'(1)) == entries);
    status.last_item  = last_item;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== tb/sv/tb_most_frequent_kmer_finder_unit.sv =====
module tb_most_frequent_kmer_finder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN    = kmf_pkg::MAX_MOTIF_DEF;
  localparam int CELLS      = kmf_pkg::TABLE_DEPTH_DEF;
  localparam int CODE_W     = kmf_pkg::CODE_W;
  localparam int CNT_W      = kmf_pkg::CNT_W;
  localparam int POS_W      = kmf_pkg::POS_W;
  localparam int CFG_W      = kmf_pkg::CFG_W;
  localparam int IDLE_PCT   = 21;
  localparam int SETTLE_CYC = 2 * CELLS + 16;
  localparam int QUIET_MAX  = 5000;
  localparam int RAND_ITEMS = 450;

  typedef struct packed {
    logic [CODE_W-1:0] motif;
    logic [CNT_W-1:0]  hits;
    logic              full;
  } motif_tally_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  kmf_in_if  in_ch();
  kmf_out_if out_ch();

  most_frequent_kmer_finder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bit steady;
  int err_cnt;
  int quiet_cyc;

  // motif counter state
  logic [CFG_W-1:0]  len_reg;
  logic [CODE_W-1:0] win_bits;
  logic [POS_W-1:0]  seed_pos;
  logic [CODE_W-1:0] cell_key [CELLS];
  logic [CNT_W-1:0]  cell_hits [CELLS];
  int                cells_used;
  logic [CNT_W-1:0]  lead_hits;
  logic [CODE_W-1:0] lead_key;
  logic              table_over;

  motif_tally_t pending_motifs [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_tally();
    win_bits   = '0;
    seed_pos   = '0;
    cells_used = 0;
    lead_hits  = '0;
    lead_key   = '0;
    table_over = 1'b0;
  endfunction

  function automatic void count_window(input logic [CODE_W-1:0] key);
    logic [CNT_W-1:0] c;
    for (int i = 0; i < cells_used; i++) begin
      if (cell_key[i] == key) begin
        c = cell_hits[i];
        if (c != kmf_pkg::CNT_SAT) c = c + 1'b1;
        cell_hits[i] = c;
        if (c > lead_hits) begin
          lead_hits = c;
          lead_key  = key;
        end
        return;
      end
    end
    if (cells_used >= CELLS) begin
      table_over = 1'b1;
      return;
    end
    cell_key[cells_used]  = key;
    cell_hits[cells_used] = CNT_W'(1);
    cells_used++;
    if (lead_hits == '0) begin
      lead_hits = CNT_W'(1);
      lead_key  = key;
    end
  endfunction

  function automatic void tally_base(input logic [1:0] code, input logic first,
                                     input logic last);
    int                m;
    int                p;
    logic [CODE_W-1:0] mask;
    motif_tally_t      r;
    if (first) clear_tally();
    m = (len_reg == '0) ? 1 : ((int'(len_reg) > MAX_LEN) ? MAX_LEN : int'(len_reg));
    p = int'(seed_pos);
    mask = CODE_W'((64'd1 << (2 * m)) - 64'd1);
    win_bits = ((win_bits << 2) | CODE_W'(code)) & mask;
    if (10 * p + 10 >= 9 * m) count_window(win_bits);
    if (seed_pos != kmf_pkg::POS_SAT) seed_pos = seed_pos + 1'b1;
    if (last) begin
      r.motif = lead_key;
      r.hits  = lead_hits;
      r.full  = table_over;
      pending_motifs = {pending_motifs, r};
    end
  endfunction

  task automatic send_base(input logic [1:0] code, input logic first, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_code  <= code;
    in_ch.seed_first <= first;
    in_ch.seed_last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    tally_base(code, first, last);
  endtask

  // only while the block is idle
  task automatic set_motif_len(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_motifs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_reg = v;
  endtask

  task automatic test_headless_items();
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd1, 1'b0, 1'b1);
    send_base(2'd1, 1'b0, 1'b0);
    send_base(2'd1, 1'b0, 1'b1);
  endtask

  task automatic test_tie_keeps_first();
    send_base(2'd2, 1'b1, 1'b0);
    send_base(2'd1, 1'b0, 1'b0);
    send_base(2'd1, 1'b0, 1'b0);
    send_base(2'd2, 1'b0, 1'b1);
  endtask

  task automatic test_len_clamp();
    set_motif_len(4'd0);
    send_base(2'd0, 1'b1, 1'b1);
    send_base(2'd3, 1'b1, 1'b0);
    send_base(2'd2, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b1);
    set_motif_len(4'd15);
    for (int i = 0; i < 10; i++)
      send_base((i % 3 == 0) ? 2'd2 : 2'd3, i == 0, i == 9);
    set_motif_len(4'd10);
    send_base(2'd1, 1'b1, 1'b0);
    send_base(2'd2, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b1);
  endtask

  task automatic test_long_seed();
    set_motif_len(4'd1);
    for (int i = 0; i < 520; i++)
      send_base(2'd2, i == 0, i == 519);
  endtask

  task automatic test_table_full();
    set_motif_len(4'd10);
    for (int i = 0; i < 300; i++)
      send_base(2'($urandom_range(3)), i == 0, i == 299);
  endtask

  task automatic test_random_seeds();
    int         items;
    int         seeds;
    int         n;
    int         mode;
    int         period;
    logic [1:0] pat [5];
    logic [1:0] pair [2];
    logic [1:0] code;
    logic       first;
    logic       last;
    items = 0;
    seeds = 0;
    while (items < RAND_ITEMS) begin
      if (seeds % 5 == 0) begin
        steady = (seeds / 5 == 3);
        set_motif_len(CFG_W'($urandom_range(15)));
      end
      n = ($urandom_range(11) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      mode   = $urandom_range(2);
      period = $urandom_range(1, 5);
      for (int k = 0; k < 5; k++) pat[k] = 2'($urandom_range(3));
      pair[0] = 2'($urandom_range(3));
      pair[1] = 2'($urandom_range(3));
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: begin
            code = 2'($urandom_range(3));
          end
          1: begin
            code = pair[$urandom_range(1)];
          end
          default: begin
            code = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : pat[i % period];
          end
        endcase
        first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
        last  = (i == n - 1) ? ($urandom_range(11) != 0) : ($urandom_range(39) == 0);
        send_base(code, first, last);
        items++;
      end
      seeds++;
    end
    steady = 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    motif_tally_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_motifs.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: motif %h hits %0d full %b",
                   out_ch.motif_code, out_ch.top_count, out_ch.table_full);
      end else begin
        want = pending_motifs.pop_front();
        if (out_ch.motif_code !== want.motif || out_ch.top_count !== want.hits ||
            out_ch.table_full !== want.full) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: want motif %h hits %0d full %b, got motif %h hits %0d full %b",
                     want.motif, want.hits, want.full,
                     out_ch.motif_code, out_ch.top_count, out_ch.table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= QUIET_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.base_code  <= 2'd0;
    in_ch.seed_first <= 1'b0;
    in_ch.seed_last  <= 1'b0;
    steady  = 1'b0;
    err_cnt = 0;
    len_reg = CFG_W'(1);
    clear_tally();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_headless_items();
    test_tie_keeps_first();
    test_len_clamp();
    test_long_seed();
    test_table_full();
    test_random_seeds();

    in_ch.valid <= 1'b0;
    while (pending_motifs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
